FILE: rtl/core/positional_list_store_macros.svh
// assertion macros shared by the positional list store rtl
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define PLS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// same-cycle implication checked at every clock edge out of reset
`define PLS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pls_pkg.sv
// package with field widths and action and status codes of the positional list store
package pls_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LENGTH_W = 5;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [BYTE_W-1:0]   byte_t;

  localparam action_t ACT_INSERT = 2'd0;
  localparam action_t ACT_DELETE = 2'd1;
  localparam action_t ACT_READ   = 2'd2;

  localparam status_t STAT_DONE  = 2'd0;
  localparam status_t STAT_RANGE = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;

endpackage

FILE: rtl/core/pls_ram.sv
// generic single write port, single read port ram with registered read data
module pls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/positional_list_store.sv
// Positional list store: an ordered list of up to CAPACITY bytes held in one ram with one
// write and one registered read port. Each input transfer carries an action (insert,
// delete, read), a position and a byte; each gives exactly one output transfer with the
// removed or read byte, a status and the length after the action. One action is worked
// at a time. An error, an unused action or an insert at the end goes straight to the
// finishing state; a read waits for the read port, a delete and an insert in the middle
// move the entries behind the position one per cycle through the ram, a read of one entry
// overlapping the write of the previous one, and an insert then writes its byte. out_tvalid
// rises when the finishing state hands the result to the output register. in_tready returns
// on the edge that raises out_tvalid; a result that is not taken holds the block in its
// finishing state and keeps in_tready low until the output register is free. Entry
// contents are undefined after reset and need no clearing pass; the length resets to zero.
`include "positional_list_store_macros.svh"

module positional_list_store #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // fields from bit 0: action[1:0], position[6:2], value[14:7], zero[15]
  input  logic [pls_pkg::IN_TDATA_W-1:0]  in_tdata,
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // fields from bit 0: entry_out[7:0], status[9:8], length[14:10], zero[15]
  output logic [pls_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import pls_pkg::*;

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_INS_SHIFT = 7'b0000010,
    S_INS_PUT   = 7'b0000100,
    S_DEL_FIRST = 7'b0001000,
    S_DEL_SHIFT = 7'b0010000,
    S_RD_WAIT   = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  byte_t             val_r, val_nxt;
  byte_t             res_data_r, res_data_nxt;
  status_t           res_status_r, res_status_nxt;
  logic              out_valid_r;
  byte_t             out_data_r;
  status_t           out_status_r;
  logic [LENGTH_W-1:0] out_length_r;

  // input field split
  action_t           in_action;
  logic [POS_W-1:0]  in_position;
  byte_t             in_value;

  // ram access
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  byte_t             mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  byte_t             mem_rdata;

  // widened values for compares
  logic [CMPW-1:0]   pos_ext;
  logic [CMPW-1:0]   count_ext;
  logic [CMPW-1:0]   count_dec_ext;
  logic [CMPW-1:0]   ptr_inc_ext;
  logic [AW-1:0]     pos_addr;
  logic [AW-1:0]     last_addr;
  logic              in_xfer;
  logic              out_load;

  assign in_action   = in_tdata[ACTION_W-1:0];
  assign in_position = in_tdata[ACTION_W+POS_W-1:ACTION_W];
  assign in_value    = in_tdata[ACTION_W+POS_W+BYTE_W-1:ACTION_W+POS_W];

  assign pos_ext       = CMPW'(in_position);
  assign count_ext     = CMPW'(count_r);
  assign count_dec_ext = count_ext - CMPW'(1);
  assign ptr_inc_ext   = CMPW'(rd_ptr_r) + CMPW'(1);
  assign pos_addr      = pos_ext[AW-1:0];
  assign last_addr     = count_dec_ext[AW-1:0];

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  pls_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_entries (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer: decode, shift entries through the ram, finish
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_ptr_nxt     = rd_ptr_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    mem_we         = 1'b0;
    mem_waddr      = rd_ptr_r;
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = rd_ptr_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_data_nxt   = '0;
          res_status_nxt = STAT_DONE;
          pos_nxt        = pos_addr;
          val_nxt        = in_value;
          state_nxt      = S_DONE;
          case (in_action)
            ACT_INSERT: begin
              if (pos_ext > count_ext) begin
                res_status_nxt = STAT_RANGE;
              end else if (count_ext == CMPW'(CAPACITY)) begin
                res_status_nxt = STAT_FULL;
              end else if (pos_ext == count_ext) begin
                // append at the end, nothing to move
                mem_we    = 1'b1;
                mem_waddr = pos_addr;
                mem_wdata = in_value;
                count_nxt = count_r + CW'(1);
              end else begin
                // start moving entries up from the last one
                mem_re     = 1'b1;
                mem_raddr  = last_addr;
                rd_ptr_nxt = last_addr;
                state_nxt  = S_INS_SHIFT;
              end
            end
            ACT_DELETE: begin
              if (pos_ext >= count_ext) begin
                res_status_nxt = STAT_RANGE;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = pos_addr;
                rd_ptr_nxt = pos_addr;
                state_nxt  = S_DEL_FIRST;
              end
            end
            ACT_READ: begin
              if (pos_ext >= count_ext) begin
                res_status_nxt = STAT_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = pos_addr;
                state_nxt = S_RD_WAIT;
              end
            end
            default: begin
              res_status_nxt = STAT_DONE;
            end
          endcase
        end
      end

      S_INS_SHIFT: begin
        // entry at rd_ptr moves one place up
        mem_we    = 1'b1;
        mem_waddr = ptr_inc_ext[AW-1:0];
        mem_wdata = mem_rdata;
        if (rd_ptr_r == pos_r) begin
          state_nxt = S_INS_PUT;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = rd_ptr_r - AW'(1);
          rd_ptr_nxt = rd_ptr_r - AW'(1);
        end
      end

      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = val_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end

      S_DEL_FIRST: begin
        // removed byte is on the read port now
        res_data_nxt = mem_rdata;
        if (ptr_inc_ext < count_ext) begin
          mem_re     = 1'b1;
          mem_raddr  = ptr_inc_ext[AW-1:0];
          rd_ptr_nxt = ptr_inc_ext[AW-1:0];
          state_nxt  = S_DEL_SHIFT;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_DEL_SHIFT: begin
        // entry at rd_ptr moves one place down
        mem_we    = 1'b1;
        mem_waddr = rd_ptr_r - AW'(1);
        mem_wdata = mem_rdata;
        if (ptr_inc_ext < count_ext) begin
          mem_re     = 1'b1;
          mem_raddr  = ptr_inc_ext[AW-1:0];
          rd_ptr_nxt = ptr_inc_ext[AW-1:0];
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_RD_WAIT: begin
        res_data_nxt = mem_rdata;
        state_nxt    = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working and result payload registers
  always_ff @(posedge clk) begin
    rd_ptr_r     <= rd_ptr_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_data_r   <= res_data_r;
      out_status_r <= res_status_r;
      out_length_r <= count_ext[LENGTH_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_length_r, out_status_r, out_data_r};

  // checks on the sequencer
  `PLS_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_ext <= CMPW'(CAPACITY),
    "length exceeds capacity")
  `PLS_ASSERT_IMPLY(a_out_from_done, clk, rst_n, $rose(out_valid_r),
    $past(state_r) == S_DONE, "result presented without finishing an action")
  `PLS_ASSERT_IMPLY(a_count_step, clk, rst_n, $past(rst_n) && (count_r != $past(count_r)),
    ($past(state_r) == S_IDLE) || ($past(state_r) == S_INS_PUT) ||
    ($past(state_r) == S_DEL_FIRST) || ($past(state_r) == S_DEL_SHIFT),
    "length changed outside an insert or delete")

endmodule
